/* src/mtfc_pkg.sv */
// Shared types and sizes for the move-to-front tag cache.
// Used by mtfc_cell and move_to_front_tag_cache_unit; no dependencies.
package mtfc_pkg;

  localparam int ENTRIES     = 8;
  localparam int KEY_BITS    = 32;
  localparam int HANDLE_BITS = 16;

  localparam logic REQ_LOOKUP = 1'b0;
  localparam logic REQ_ADD    = 1'b1;

  typedef struct packed {
    logic                   valid;
    logic [KEY_BITS-1:0]    key;
    logic                   key_present;
    logic [HANDLE_BITS-1:0] handle;
  } entry_t;

  // first-match chain running from slot 0 toward the last slot
  typedef struct packed {
    logic                   found;
    logic [HANDLE_BITS-1:0] handle;
  } link_t;

  typedef struct packed {
    logic fire;
    logic is_add;
    logic hit_any;
  } ctrl_t;

endpackage

/* src/mtfc_cell.sv */
// One cache slot: holds an entry, compares it with the request key and
// shifts in its neighbor's entry. Depends on mtfc_pkg.
module mtfc_cell (
  input  logic                              clk,
  input  logic                              rst,
  input  mtfc_pkg::ctrl_t                   ctrl,
  input  logic [mtfc_pkg::KEY_BITS-1:0]     key,
  input  mtfc_pkg::entry_t                  prev,
  input  mtfc_pkg::link_t                   link_in,
  output mtfc_pkg::link_t                   link_out,
  output mtfc_pkg::entry_t                  ent
);

  logic match;
  logic shift;

  assign match = !ctrl.is_add && ent.valid && ent.key_present && (ent.key == key);

  always_comb begin
    if (link_in.found) begin
      link_out = link_in;
    end else begin
      link_out.found  = match;
      link_out.handle = match ? ent.handle : '0;
    end
  end

  // lookup hit at or past this slot, or any add
  assign shift = ctrl.fire && (ctrl.is_add || (ctrl.hit_any && !link_in.found));

  always_ff @(posedge clk) begin
    if (shift) begin
      ent.key         <= prev.key;
      ent.key_present <= prev.key_present;
      ent.handle      <= prev.handle;
    end
    if (rst) begin
      ent.valid <= 1'b0;
    end else if (shift) begin
      ent.valid <= prev.valid;
    end
  end

endmodule

/* src/move_to_front_tag_cache_unit.sv */
// Top level of the move-to-front tag cache: request hold register, chain of
// slot cells and response register. Depends on mtfc_pkg and mtfc_cell.

// Recency-ordered cache of key-to-handle entries, slot 0 most recent. A lookup
// (req_type 0) returns the handle of the valid keyed entry nearest slot 0 whose
// key matches and moves it to the front; an add (req_type 1) pushes every entry
// back one slot, reports the handle that falls out of the last slot and places
// the new entry at the front. Each item gives exactly one response item. The
// block sustains one item per cycle while rsp_stall does not hold it back; an item's
// request is loaded into the hold register at acceptance and its response into the
// response register when it is processed, which a response stall can delay. The
// critical path is the compare and shift across the cell chain, whose first-match
// chain runs through all ENTRIES cells. After reset all slots are empty.
module move_to_front_tag_cache_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               req_valid,
  output logic                               req_stall,
  input  logic                               req_type,
  input  logic [mtfc_pkg::KEY_BITS-1:0]      key,
  input  logic                               key_present,
  input  logic [mtfc_pkg::HANDLE_BITS-1:0]   handle,
  output logic                               rsp_valid,
  input  logic                               rsp_stall,
  output logic                               hit,
  output logic [mtfc_pkg::HANDLE_BITS-1:0]   hit_handle,
  output logic                               evicted_valid,
  output logic [mtfc_pkg::HANDLE_BITS-1:0]   evicted_handle
);

  logic                             q_valid;
  logic                             q_type;
  logic [mtfc_pkg::KEY_BITS-1:0]    q_key;
  logic                             q_kp;
  logic [mtfc_pkg::HANDLE_BITS-1:0] q_handle;

  logic             fire;
  logic             is_add;
  mtfc_pkg::ctrl_t  ctrl;
  mtfc_pkg::entry_t front;
  mtfc_pkg::entry_t ent [mtfc_pkg::ENTRIES];
  mtfc_pkg::link_t  lnk [mtfc_pkg::ENTRIES+1];

  assign fire      = q_valid && (!rsp_valid || !rsp_stall);
  assign req_stall = q_valid && !fire;
  assign is_add    = (q_type == mtfc_pkg::REQ_ADD);

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (req_valid && !req_stall) begin
      q_valid <= 1'b1;
    end else if (fire) begin
      q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      q_type   <= req_type;
      q_key    <= key;
      q_kp     <= key_present;
      q_handle <= handle;
    end
  end

  assign lnk[0] = '0;

  assign ctrl.fire    = fire;
  assign ctrl.is_add  = is_add;
  assign ctrl.hit_any = lnk[mtfc_pkg::ENTRIES].found;

  always_comb begin
    front.valid       = 1'b1;
    front.key         = q_key;
    front.key_present = is_add ? q_kp : 1'b1;
    front.handle      = is_add ? q_handle : lnk[mtfc_pkg::ENTRIES].handle;
  end

  for (genvar i = 0; i < mtfc_pkg::ENTRIES; i++) begin : g_cell
    mtfc_pkg::entry_t prev;
    if (i == 0) begin : g_head
      assign prev = front;
    end else begin : g_body
      assign prev = ent[i-1];
    end
    mtfc_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl),
      .key      (q_key),
      .prev     (prev),
      .link_in  (lnk[i]),
      .link_out (lnk[i+1]),
      .ent      (ent[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (fire) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      hit            <= !is_add && ctrl.hit_any;
      hit_handle     <= (!is_add && ctrl.hit_any) ? lnk[mtfc_pkg::ENTRIES].handle : '0;
      evicted_valid  <= is_add && ent[mtfc_pkg::ENTRIES-1].valid;
      evicted_handle <= (is_add && ent[mtfc_pkg::ENTRIES-1].valid) ?
                        ent[mtfc_pkg::ENTRIES-1].handle : '0;
    end
  end

  a_excl_result: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(hit && evicted_valid))
    else $error("hit and eviction in one response");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> q_valid)
    else $error("request stalled with empty hold register");

  a_fire_rsp: assert property (@(posedge clk) disable iff (rst)
    fire |=> rsp_valid)
    else $error("processed item gave no response");

  a_hit_front: assert property (@(posedge clk) disable iff (rst)
    (fire && !is_add && ctrl.hit_any) |=>
      (ent[0].valid && ent[0].key_present && ent[0].key == $past(q_key)))
    else $error("hit entry not moved to front");

  a_add_front: assert property (@(posedge clk) disable iff (rst)
    (fire && is_add) |=> (ent[0].valid && ent[0].handle == $past(q_handle)))
    else $error("added entry not at front");

endmodule

/* sim/tb.sv */
// Self-checking testbench for move_to_front_tag_cache_unit: directed table, then random
// lookup/add traffic checked against a move-to-front predictor with random idle and stalls.
// Depends on mtfc_pkg and the cache RTL.
`timescale 1ns / 100ps

module tb;

  localparam int HOLD_CYCLES = 40;
  localparam int STALL_LIMIT = 2000;
  localparam int POOL_SIZE   = 16;

  typedef logic [mtfc_pkg::HANDLE_BITS-1:0] handle_t;
  typedef logic [mtfc_pkg::KEY_BITS-1:0]    key_t;
  typedef logic [$clog2(POOL_SIZE)-1:0]     pool_idx_t;

  typedef struct packed {
    logic    hit;
    handle_t hit_handle;
    logic    ev_valid;
    handle_t ev_handle;
  } outcome_t;

  typedef struct packed {
    logic     rtype;
    key_t     key;
    logic     key_present;
    handle_t  handle;
    logic     typed;
    outcome_t res;
  } plan_row_t;

  localparam outcome_t NOTHING = '0;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    req_valid = 1'b0;
  logic    req_stall;
  logic    req_type = mtfc_pkg::REQ_LOOKUP;
  key_t    key = '0;
  logic    key_present = 1'b0;
  handle_t handle = '0;
  logic    rsp_valid;
  logic    rsp_stall = 1'b0;
  logic    hit;
  handle_t hit_handle;
  logic    evicted_valid;
  handle_t evicted_handle;

  mtfc_pkg::entry_t mirror_slots [mtfc_pkg::ENTRIES];
  outcome_t         pending_results [$];
  outcome_t         oldest;
  key_t             key_pool [POOL_SIZE];
  int unsigned      fail_count = 0;
  bit               quiet = 1'b0;
  bit               pressure = 1'b0;
  bit               hold_off_req = 1'b0;

  plan_row_t opening_plan [0:22] = '{
    '{mtfc_pkg::REQ_LOOKUP, 32'h0000_0000, 1'b0, 16'h0000, 1'b1, NOTHING},
    '{mtfc_pkg::REQ_LOOKUP, 32'hFFFF_FFFF, 1'b1, 16'hFFFF, 1'b1, NOTHING},
    '{mtfc_pkg::REQ_ADD,    32'h0000_0000, 1'b1, 16'h0000, 1'b1, NOTHING},
    '{mtfc_pkg::REQ_ADD,    32'hFFFF_FFFF, 1'b1, 16'hFFFF, 1'b1, NOTHING},
    '{mtfc_pkg::REQ_LOOKUP, 32'hFFFF_FFFF, 1'b0, 16'h0000, 1'b1,
      '{1'b1, 16'hFFFF, 1'b0, 16'h0000}},
    '{mtfc_pkg::REQ_LOOKUP, 32'h0000_0000, 1'b0, 16'h0000, 1'b1,
      '{1'b1, 16'h0000, 1'b0, 16'h0000}},
    '{mtfc_pkg::REQ_ADD,    32'h1234_5678, 1'b0, 16'h1111, 1'b1, NOTHING},
    '{mtfc_pkg::REQ_LOOKUP, 32'h1234_5678, 1'b0, 16'h0000, 1'b1, NOTHING},
    '{mtfc_pkg::REQ_ADD,    32'hA5A5_A5A5, 1'b1, 16'h2222, 1'b1, NOTHING},
    '{mtfc_pkg::REQ_ADD,    32'hA5A5_A5A5, 1'b1, 16'h3333, 1'b1, NOTHING},
    '{mtfc_pkg::REQ_LOOKUP, 32'hA5A5_A5A5, 1'b0, 16'h0000, 1'b1,
      '{1'b1, 16'h3333, 1'b0, 16'h0000}},
    '{mtfc_pkg::REQ_LOOKUP, 32'h5A5A_5A5A, 1'b1, 16'hFFFF, 1'b1, NOTHING},
    '{mtfc_pkg::REQ_ADD,    32'h0000_0001, 1'b1, 16'h8000, 1'b1, NOTHING},
    '{mtfc_pkg::REQ_ADD,    32'h8000_0000, 1'b1, 16'h7FFF, 1'b1, NOTHING},
    '{mtfc_pkg::REQ_ADD,    32'h7FFF_FFFF, 1'b1, 16'h0001, 1'b1, NOTHING},
    '{mtfc_pkg::REQ_ADD,    32'hDEAD_BEEF, 1'b1, 16'hBEEF, 1'b1,
      '{1'b0, 16'h0000, 1'b1, 16'hFFFF}},
    '{mtfc_pkg::REQ_LOOKUP, 32'h0000_0000, 1'b0, 16'h0000, 1'b0, NOTHING},
    '{mtfc_pkg::REQ_ADD,    32'hCAFE_F00D, 1'b1, 16'h0F0F, 1'b0, NOTHING},
    '{mtfc_pkg::REQ_LOOKUP, 32'hFFFF_FFFF, 1'b0, 16'h0000, 1'b0, NOTHING},
    '{mtfc_pkg::REQ_LOOKUP, 32'h8000_0000, 1'b0, 16'h0000, 1'b0, NOTHING},
    '{mtfc_pkg::REQ_ADD,    32'h0000_0000, 1'b1, 16'h5555, 1'b0, NOTHING},
    '{mtfc_pkg::REQ_LOOKUP, 32'h0000_0000, 1'b0, 16'h0000, 1'b0, NOTHING},
    '{mtfc_pkg::REQ_LOOKUP, 32'hA5A5_A5A5, 1'b0, 16'h0000, 1'b0, NOTHING}
  };

  move_to_front_tag_cache_unit DUT (
    .clk            (clk),
    .rst            (rst),
    .req_valid      (req_valid),
    .req_stall      (req_stall),
    .req_type       (req_type),
    .key            (key),
    .key_present    (key_present),
    .handle         (handle),
    .rsp_valid      (rsp_valid),
    .rsp_stall      (rsp_stall),
    .hit            (hit),
    .hit_handle     (hit_handle),
    .evicted_valid  (evicted_valid),
    .evicted_handle (evicted_handle)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // recency order: slot 0 is the most recent entry
  function automatic outcome_t mtf_predict(logic rtype, key_t k, logic kp, handle_t h);
    outcome_t         r;
    mtfc_pkg::entry_t moved;
    int               idx;
    r = '0;
    idx = -1;
    if (rtype == mtfc_pkg::REQ_LOOKUP) begin
      for (int i = mtfc_pkg::ENTRIES - 1; i >= 0; i--)
        if (mirror_slots[i].valid && mirror_slots[i].key_present && mirror_slots[i].key == k)
          idx = i;
      if (idx >= 0) begin
        moved = mirror_slots[idx];
        for (int j = idx; j >= 1; j--) mirror_slots[j] = mirror_slots[j-1];
        mirror_slots[0] = moved;
        r.hit = 1'b1;
        r.hit_handle = moved.handle;
      end
    end else begin
      if (mirror_slots[mtfc_pkg::ENTRIES-1].valid) begin
        r.ev_valid = 1'b1;
        r.ev_handle = mirror_slots[mtfc_pkg::ENTRIES-1].handle;
      end
      for (int j = mtfc_pkg::ENTRIES - 1; j >= 1; j--) mirror_slots[j] = mirror_slots[j-1];
      mirror_slots[0].valid = 1'b1;
      mirror_slots[0].key = k;
      mirror_slots[0].key_present = kp;
      mirror_slots[0].handle = h;
    end
    return r;
  endfunction

  task automatic offer_item(input logic rtype, input key_t k, input logic kp,
                            input handle_t h, input logic typed,
                            input outcome_t typed_res);
    outcome_t predicted;
    @(negedge clk);
    req_type = rtype;
    key = k;
    key_present = kp;
    handle = h;
    req_valid = 1'b1;
    do @(posedge clk); while (req_stall);
    predicted = mtf_predict(rtype, k, kp, h);
    pending_results = {pending_results, (typed ? typed_res : predicted)};
  endtask

  task automatic maybe_idle();
    int n;
    if (!quiet && !pressure && $urandom_range(0, 5) == 0) begin
      n = $urandom_range(1, 5);
      repeat (n) begin
        @(negedge clk);
        req_valid = 1'b0;
        key = key_t'($urandom);
        handle = handle_t'($urandom);
      end
    end
  endtask

  // keys mostly from a small pool so lookups hit and duplicates occur
  task automatic run_random(input int count);
    logic    rtype;
    key_t    k;
    logic    kp;
    handle_t h;
    for (int n = 0; n < count; n++) begin
      maybe_idle();
      rtype = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 9) < 7) k = key_pool[pool_idx_t'($urandom)];
      else begin
        k = key_t'($urandom);
        if (rtype == mtfc_pkg::REQ_ADD) key_pool[pool_idx_t'($urandom)] = k;
      end
      kp = ($urandom_range(0, 7) != 0);
      h = handle_t'($urandom);
      offer_item(rtype, k, kp, h, 1'b0, NOTHING);
    end
  endtask

  task automatic compare_field(input string name, input handle_t want, input handle_t got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && rsp_valid === 1'b1 && !rsp_stall) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result item: hit %0h hit_handle %0h evicted_valid %0h %s %0h",
               hit, hit_handle, evicted_valid, "evicted_handle", evicted_handle);
        fail_count++;
      end else begin
        oldest = pending_results.pop_front();
        compare_field("hit", handle_t'(oldest.hit), handle_t'(hit));
        compare_field("hit_handle", oldest.hit_handle, hit_handle);
        compare_field("evicted_valid", handle_t'(oldest.ev_valid), handle_t'(evicted_valid));
        compare_field("evicted_handle", oldest.ev_handle, evicted_handle);
      end
    end
  end

  initial begin
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall_left = HOLD_CYCLES;
      end else if (stall_left == 0 && !quiet && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 5);
      end
      rsp_stall = (stall_left != 0);
      if (stall_left != 0) stall_left--;
    end
  end

  initial begin
    int unsigned still_cycles;
    still_cycles = 0;
    wait (!rst);
    while (still_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((req_valid && !req_stall) || (rsp_valid === 1'b1 && !rsp_stall)) still_cycles = 0;
      else still_cycles++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin
    for (int i = 0; i < mtfc_pkg::ENTRIES; i++) mirror_slots[i] = '0;
    for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = key_t'($urandom);
    key_pool[0] = '0;
    key_pool[1] = '1;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (opening_plan[i]) begin
      maybe_idle();
      offer_item(opening_plan[i].rtype, opening_plan[i].key, opening_plan[i].key_present,
                 opening_plan[i].handle, opening_plan[i].typed, opening_plan[i].res);
    end

    run_random(400);

    // receiver holds off while items keep coming, so the input backs up
    pressure = 1'b1;
    hold_off_req = 1'b1;
    run_random(30);
    pressure = 1'b0;

    // sender pauses until the pipe is empty
    @(negedge clk);
    req_valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);

    run_random(400);
    quiet = 1'b1;
    run_random(150);

    @(negedge clk);
    req_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    if (fail_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule

/* files.f */
src/mtfc_pkg.sv
src/mtfc_cell.sv
src/move_to_front_tag_cache_unit.sv
sim/tb.sv
